// ===== rtl/lvl_dith_pkg.sv =====
// Package for the level-to-dithered-bitstream unit.
// Holds field widths, the phase modulus and the constant pattern ROM builder.
// No dependencies.
package lvl_dith_pkg;

    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned PATTERN_W   = 8;
    localparam int unsigned PHASE_W     = 9;
    localparam int unsigned PHASE_MOD   = 280;
    localparam int unsigned MAX_LEVEL   = 8;
    localparam int unsigned CLEVEL_W    = 4;
    localparam int unsigned NUM_LEVELS  = MAX_LEVEL + 1;
    localparam int unsigned ROM_DEPTH   = NUM_LEVELS * PHASE_MOD;
    localparam int unsigned ROM_ADDR_W  = $clog2(ROM_DEPTH);
    localparam int unsigned MAX_CLASS   = 70;

    typedef logic [PATTERN_W-1:0] pattern_t;
    typedef pattern_t pattern_rom_t [0:ROM_DEPTH-1];

    // Row lvl, column p: the (p mod C(8,lvl))-th byte of popcount lvl, ascending.
    function automatic pattern_rom_t build_pattern_rom();
        pattern_rom_t rom;
        pattern_t     members [0:MAX_CLASS-1];
        pattern_t     cand;
        int           count;
        int           ones;
        int           pick;
        for (int lvl = 0; lvl < int'(NUM_LEVELS); lvl++)
        begin
            count = 0;
            for (int v = 0; v < 256; v++)
            begin
                cand = PATTERN_W'(v);
                ones = 0;
                for (int b = 0; b < int'(PATTERN_W); b++)
                begin
                    ones = ones + int'(cand[b]);
                end
                if (ones == lvl)
                begin
                    members[count] = cand;
                    count = count + 1;
                end
            end
            pick = 0;
            for (int p = 0; p < int'(PHASE_MOD); p++)
            begin
                rom[lvl * int'(PHASE_MOD) + p] = members[pick];
                if (pick == count - 1)
                begin
                    pick = 0;
                end
                else
                begin
                    pick = pick + 1;
                end
            end
        end
        return rom;
    endfunction

endpackage

// ===== rtl/level_to_dithered_bitstream_unit.sv =====
// Level-to-dithered-bitstream unit: top level.
// Depends on lvl_dith_pkg (widths, phase modulus, pattern ROM builder).
// Contains the phase register, the registered pattern ROM read and the output stage.
// Usage
//   Sample channel: level and random_step, qualified by sample_valid; a
//   transaction completes at a rising edge with sample_valid high and
//   sample_stall low. Levels above 8 saturate to 8. Pattern channel:
//   bit_pattern, qualified by pattern_valid; a transaction completes at a
//   rising edge with pattern_valid high and pattern_stall low. Every sample
//   transaction yields exactly one pattern, in order.
// Throughput and read path
//   One sample per cycle while sample_stall is low. The pattern ROM (9 x 280
//   bytes, one synchronous read port) is read into the read slot at the edge
//   that takes the sample, moves to the output register once that is free
//   and is shown there. The phase update (one add and a conditional subtract)
//   completes in the same cycle, so back-to-back samples need no interlock.
// Stalls and reset
//   A ROM read stage and an output register give two slots; sample_stall
//   rises only when both hold patterns and the receiver stalls. rst_n
//   (asynchronous, active low) zeroes the phase and empties both slots.
module level_to_dithered_bitstream_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [lvl_dith_pkg::LEVEL_W-1:0]   level,
    input  logic [lvl_dith_pkg::STEP_W-1:0]    random_step,
    output logic                               pattern_valid,
    input  logic                               pattern_stall,
    output logic [lvl_dith_pkg::PATTERN_W-1:0] bit_pattern
);
    import lvl_dith_pkg::*;

    // Constant 9 x 280 pattern store, read through a registered port.
    localparam pattern_rom_t PATTERN_ROM = build_pattern_rom();

    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [PHASE_W:0]      phase_sum;
    logic [CLEVEL_W-1:0]   clamped_level;
    logic [ROM_ADDR_W-1:0] rom_addr;

    logic     rd_valid_reg;
    logic     rd_valid_next;
    pattern_t rd_data_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    pattern_t out_data_reg;

    logic sample_take;
    logic rd_move;
    logic rd_free;
    logic out_free;

    // Handshake: the output slot frees when empty or when its pattern is taken;
    // the read slot frees when empty or when it moves into the output slot.
    always_comb
    begin
        out_free     = !out_valid_reg || !pattern_stall;
        rd_move      = rd_valid_reg && out_free;
        rd_free      = !rd_valid_reg || rd_move;
        sample_stall = !rd_free;
        sample_take  = sample_valid && rd_free;
    end

    // Saturate the level, form the ROM address and the wrapped phase.
    always_comb
    begin
        if (level > LEVEL_W'(MAX_LEVEL))
        begin
            clamped_level = CLEVEL_W'(MAX_LEVEL);
        end
        else
        begin
            clamped_level = level[CLEVEL_W-1:0];
        end
        rom_addr  = ROM_ADDR_W'(clamped_level) * ROM_ADDR_W'(PHASE_MOD)
                  + ROM_ADDR_W'(phase_reg);
        phase_sum = (PHASE_W+1)'(phase_reg) + (PHASE_W+1)'(random_step);
        if (phase_sum >= (PHASE_W+1)'(PHASE_MOD))
        begin
            phase_next = PHASE_W'(phase_sum - (PHASE_W+1)'(PHASE_MOD));
        end
        else
        begin
            phase_next = phase_sum[PHASE_W-1:0];
        end
    end

    // Slot occupancy: hold, fill or drain each slot.
    always_comb
    begin
        rd_valid_next  = sample_take || (rd_valid_reg && !rd_move);
        out_valid_next = rd_move || (out_valid_reg && pattern_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (sample_take)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    // ROM read port: load only on an accepted sample, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            rd_data_reg <= PATTERN_ROM[rom_addr];
        end
    end

    // Output register: advance when the read slot moves.
    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            out_data_reg <= rd_data_reg;
        end
    end

    assign pattern_valid = out_valid_reg;
    assign bit_pattern   = out_data_reg;

endmodule

// ===== tb/level_to_dithered_bitstream_unit_tb.sv =====
// Self-checking testbench for level_to_dithered_bitstream_unit: drives level samples with
// random steps and checks each returned pattern against a built-in phase predictor.
// Depends on lvl_dith_pkg and the unit under test; no files, no arguments.
`timescale 1ns / 100ps

module level_to_dithered_bitstream_unit_tb;

    import lvl_dith_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 1200;
    localparam int unsigned DRAIN_CYCLES  = 8;

    typedef struct packed
    {
        logic [LEVEL_W-1:0] level;
        logic [STEP_W-1:0]  step;
    } sample_item_t;

    // Receiver behaviour; one mode holds for a stretch of cycles.
    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS,
        STALL_EVERY_THIRD
    } stall_mode_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 sample_valid  = 1'b0;
    logic                 sample_stall;
    logic [LEVEL_W-1:0]   level         = '0;
    logic [STEP_W-1:0]    random_step   = '0;
    logic                 pattern_valid;
    logic                 pattern_stall = 1'b0;
    logic [PATTERN_W-1:0] bit_pattern;

    sample_item_t         pending_samples [$];
    pattern_t             expected_patterns [$];
    logic [PHASE_W-1:0]   predicted_phase = '0;
    logic                 sample_taken    = 1'b0;
    int unsigned          samples_taken   = 0;
    int unsigned          samples_total   = 0;
    int unsigned          error_count     = 0;
    int unsigned          cycle_count     = 0;

    int unsigned          burst_left      = 1;
    int unsigned          gap_left        = 0;
    stall_mode_t          stall_mode      = STALL_NONE;
    int unsigned          stall_mode_left = 0;
    int unsigned          stall_run       = 0;
    logic                 stall_hold      = 1'b0;
    int unsigned          stall_tick      = 0;

    level_to_dithered_bitstream_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .level         (level),
        .random_step   (random_step),
        .pattern_valid (pattern_valid),
        .pattern_stall (pattern_stall),
        .bit_pattern   (bit_pattern)
    );

    always #5 clk = ~clk;

    // Pattern for one sample: saturate the level, then walk the bytes of that
    // popcount in ascending order and take the one at phase mod class size.
    function automatic pattern_t dithered_pattern(logic [LEVEL_W-1:0] lvl_in,
                                                  logic [PHASE_W-1:0] cur_phase);
        int unsigned ones_wanted;
        int unsigned class_size;
        int unsigned slot;
        int unsigned seen;
        pattern_t    found;
        ones_wanted = (lvl_in > MAX_LEVEL) ? MAX_LEVEL : int'(lvl_in);
        class_size  = 0;
        for (int v = 0; v < 256; v++)
        begin
            if ($countones(8'(v)) == ones_wanted)
                class_size++;
        end
        slot  = int'(cur_phase) % class_size;
        seen  = 0;
        found = '0;
        for (int v = 0; v < 256; v++)
        begin
            if ($countones(8'(v)) == ones_wanted)
            begin
                if (seen == slot)
                    found = PATTERN_W'(v);
                seen++;
            end
        end
        return found;
    endfunction

    // Advance the phase by the step, wrapping at the modulus with one subtract.
    function automatic logic [PHASE_W-1:0] advanced_phase(logic [PHASE_W-1:0] cur_phase,
                                                          logic [STEP_W-1:0] step);
        int unsigned sum;
        sum = int'(cur_phase) + int'(step);
        if (sum >= PHASE_MOD)
            sum = sum - PHASE_MOD;
        return PHASE_W'(sum);
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        sample_item_t item;
        int unsigned  pick;

        // Directed: level zero at two phases, every level, saturation,
        // all level bits, and runs of large steps to force the phase to wrap.
        pending_samples.push_back('{level: 8'd0,   step: 8'd0});
        pending_samples.push_back('{level: 8'd8,   step: 8'd1});
        pending_samples.push_back('{level: 8'd9,   step: 8'd0});
        pending_samples.push_back('{level: 8'd255, step: 8'd255});
        pending_samples.push_back('{level: 8'd1,   step: 8'd7});
        pending_samples.push_back('{level: 8'd2,   step: 8'd3});
        pending_samples.push_back('{level: 8'd3,   step: 8'd45});
        pending_samples.push_back('{level: 8'd4,   step: 8'd200});
        pending_samples.push_back('{level: 8'd5,   step: 8'd128});
        pending_samples.push_back('{level: 8'd6,   step: 8'd64});
        pending_samples.push_back('{level: 8'd7,   step: 8'd32});
        pending_samples.push_back('{level: 8'd8,   step: 8'd16});
        pending_samples.push_back('{level: 8'd128, step: 8'd1});
        pending_samples.push_back('{level: 8'd170, step: 8'd2});
        pending_samples.push_back('{level: 8'd85,  step: 8'd4});
        pending_samples.push_back('{level: 8'd0,   step: 8'd8});
        pending_samples.push_back('{level: 8'd3,   step: 8'd255});
        pending_samples.push_back('{level: 8'd5,   step: 8'd255});
        pending_samples.push_back('{level: 8'd2,   step: 8'd255});
        pending_samples.push_back('{level: 8'd6,   step: 8'd254});
        pending_samples.push_back('{level: 8'd7,   step: 8'd0});
        pending_samples.push_back('{level: 8'd1,   step: 8'd170});
        pending_samples.push_back('{level: 8'd4,   step: 8'd85});

        // Random: mostly meaningful levels, some saturating and some fully random.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                item.level = LEVEL_W'($urandom_range(0, MAX_LEVEL));
            else if (pick == 8)
                item.level = LEVEL_W'($urandom_range(MAX_LEVEL + 1, 255));
            else
                item.level = LEVEL_W'($urandom);
            item.step = STEP_W'($urandom);
            pending_samples.push_back(item);
        end
        samples_total = pending_samples.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (samples_taken < samples_total)
            @(posedge clk);
        while (expected_patterns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sender: present samples in bursts of random length with random gaps
    // between them; a quarter of bursts run straight into the next one.
    always @(negedge clk)
    begin
        sample_item_t next_item;
        logic         drive_valid;
        drive_valid = sample_valid;
        if (rst_n)
        begin
            // Drop valid once the held transaction has gone through.
            if (sample_valid && sample_taken)
                drive_valid = 1'b0;
            if (!drive_valid && pending_samples.size() != 0)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else
                begin
                    next_item   = pending_samples.pop_front();
                    drive_valid = 1'b1;
                    level       <= next_item.level;
                    random_step <= next_item.step;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            sample_valid <= drive_valid;
        end
    end

    // Receiver: pick a stall mode for a stretch of cycles and apply it.
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = stall_mode_t'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:
            begin
                pattern_stall <= 1'b0;
            end
            STALL_COIN:
            begin
                pattern_stall <= ($urandom_range(0, 1) == 1);
            end
            STALL_RUNS:
            begin
                // Alternate long stalls with shorter open windows.
                if (stall_run == 0)
                begin
                    stall_hold = ~stall_hold;
                    stall_run  = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                else
                begin
                    stall_run--;
                end
                pattern_stall <= stall_hold;
            end
            default:
            begin
                pattern_stall <= (stall_tick % 3 == 0);
            end
        endcase
    end

    // Monitor: check each pattern transaction against the oldest expectation,
    // then predict the pattern for each sample transaction taken this edge.
    always @(posedge clk)
    begin
        pattern_t want;
        if (rst_n)
        begin
            if (pattern_valid && !pattern_stall)
            begin
                if (expected_patterns.size() == 0)
                begin
                    $error("bit_pattern: expected none, actual %02h", bit_pattern);
                    error_count++;
                end
                else
                begin
                    want = expected_patterns.pop_front();
                    if (bit_pattern !== want)
                    begin
                        $error("bit_pattern: expected %02h, actual %02h", want, bit_pattern);
                        error_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                expected_patterns.push_back(dithered_pattern(level, predicted_phase));
                predicted_phase = advanced_phase(predicted_phase, random_step);
                samples_taken++;
            end
        end
        sample_taken <= rst_n && sample_valid && !sample_stall;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/lvl_dith_pkg.sv
rtl/level_to_dithered_bitstream_unit.sv
tb/level_to_dithered_bitstream_unit_tb.sv
